// File: src/kbse_pkg.sv
package kbse_pkg;

  localparam int unsigned ANGLE_W       = 17;
  localparam int unsigned ORDER_W       = 2;
  localparam int unsigned RADIUS_W      = 23;
  localparam int unsigned OUT_W         = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd65536;

  // Q30 trig values, signed, magnitude up to 1.0
  localparam int unsigned TQ     = 30;
  localparam int unsigned TRIG_W = TQ + 2;
  // w[] / b[] terms, up to 5.0 in Q30
  localparam int unsigned WB_W   = TQ + 4;

  localparam int unsigned HORNER_N  = 5;
  // reduce, x, x^2, three stages per Horner step, final multiply, octant fix
  localparam int unsigned TRIG_LAT  = 3 + 3 * HORNER_N + 2;
  // trig plus magnitude, product and combine stages
  localparam int unsigned FRONT_LAT = TRIG_LAT + 3;

  localparam logic [ORDER_W-1:0] ORDER_MAX = 2'd2;

  typedef struct packed {
    logic [ORDER_W-1:0]         uo;
    logic [ORDER_W-1:0]         vo;
    logic [2:0][WB_W-1:0]       w;
    logic [2:0][WB_W-1:0]       b;
    logic [TRIG_W-1:0]          fu_s;
    logic [TRIG_W-1:0]          fu_c;
  } kbse_item_t;

endpackage

// File: src/kbse_trig.sv
module kbse_trig (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [kbse_pkg::ANGLE_W-1:0]       angle_i,
  output logic signed [kbse_pkg::TRIG_W-1:0] sin_o,
  output logic signed [kbse_pkg::TRIG_W-1:0] cos_o
);
  import kbse_pkg::*;

  localparam int unsigned XW = TQ;
  localparam int unsigned TW = TQ + 1;
  localparam logic [TW-1:0] TONE = TW'(1) << TQ;
  localparam logic [31:0] PI_Q30 = 32'hC90F_DAA2;
  localparam int unsigned SIN_DIV [HORNER_N] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [HORNER_N] = '{90, 56, 30, 12, 2};

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] x2;
    logic [1:0]    quad;
    logic          swap;
  } side_t;

  // stage 1: octant reduction
  logic [14:0] r_raw, r_red;
  logic [15:0] r_sub;
  logic [14:0] r1_q;
  logic [1:0]  quad1_q, quad2_q;
  logic        swap1_q, swap2_q;

  always_comb begin
    r_raw = angle_i[14:0];
    r_sub = 16'h8000 - {1'b0, r_raw};
    r_red = (r_raw > 15'h4000) ? r_sub[14:0] : r_raw;
  end

  // stage 2: radians in Q30
  logic [46:0]   xprod;
  logic [XW-1:0] x2s_q;
  assign xprod = 47'(r1_q) * 47'(PI_Q30) + 47'h8000;

  // stage 3: x^2
  logic [2*XW-1:0] sqprod;
  side_t           s3_q;
  assign sqprod = (2*XW)'(x2s_q) * (2*XW)'(x2s_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q    <= r_red;
      quad1_q <= angle_i[16:15];
      swap1_q <= (r_raw > 15'h4000);
      x2s_q   <= xprod[16 +: XW];
      quad2_q <= quad1_q;
      swap2_q <= swap1_q;
      s3_q    <= '{x: x2s_q, x2: sqprod[TQ +: XW], quad: quad2_q, swap: swap2_q};
    end
  end

  side_t         side_c [HORNER_N+1];
  logic [TW-1:0] ts_c   [HORNER_N+1];
  logic [TW-1:0] tc_c   [HORNER_N+1];

  assign side_c[0] = s3_q;
  assign ts_c[0]   = TONE;
  assign tc_c[0]   = TONE;

  // Horner steps: truncating product, reciprocal divide, correct and subtract
  for (genvar k = 0; k < HORNER_N; k++) begin : g_step
    localparam logic [31:0] SM = 32'((64'd1 << 32) / 64'(SIN_DIV[k]));
    localparam logic [31:0] CM = 32'((64'd1 << 32) / 64'(COS_DIV[k]));
    localparam logic [XW:0] SD = (XW+1)'(SIN_DIV[k]);
    localparam logic [XW:0] CD = (XW+1)'(COS_DIV[k]);

    logic [XW+TW-1:0] ps_prod, pc_prod;
    logic [XW+31:0]   sq_prod, cq_prod;
    logic [XW:0]      sqd, cqd, srem, crem;
    logic [XW-1:0]    sqf, cqf;
    side_t            sa_q, sb_q, so_q;
    logic [XW-1:0]    nsa_q, nca_q, nsb_q, ncb_q, qsb_q, qcb_q;
    logic [TW-1:0]    tso_q, tco_q;

    always_comb begin
      ps_prod = (XW+TW)'(side_c[k].x2) * (XW+TW)'(ts_c[k]);
      pc_prod = (XW+TW)'(side_c[k].x2) * (XW+TW)'(tc_c[k]);
      sq_prod = (XW+32)'(nsa_q) * (XW+32)'(SM);
      cq_prod = (XW+32)'(nca_q) * (XW+32)'(CM);
      sqd     = (XW+1)'(qsb_q) * SD;
      cqd     = (XW+1)'(qcb_q) * CD;
      srem    = {1'b0, nsb_q} - sqd;
      crem    = {1'b0, ncb_q} - cqd;
      sqf     = qsb_q + XW'(srem >= SD);
      cqf     = qcb_q + XW'(crem >= CD);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sa_q  <= side_c[k];
        nsa_q <= ps_prod[TQ +: XW];
        nca_q <= pc_prod[TQ +: XW];
        sb_q  <= sa_q;
        nsb_q <= nsa_q;
        ncb_q <= nca_q;
        qsb_q <= sq_prod[32 +: XW];
        qcb_q <= cq_prod[32 +: XW];
        so_q  <= sb_q;
        tso_q <= TONE - TW'(sqf);
        tco_q <= TONE - TW'(cqf);
      end
    end

    assign side_c[k+1] = so_q;
    assign ts_c[k+1]   = tso_q;
    assign tc_c[k+1]   = tco_q;
  end

  // final sine multiply by x
  logic [XW+TW-1:0] fprod;
  side_t            sf_q;
  logic [TW-1:0]    tsf_q, tcf_q;
  assign fprod = (XW+TW)'(side_c[HORNER_N].x) * (XW+TW)'(ts_c[HORNER_N]);

  // octant swap and quadrant signs
  logic [TW-1:0]            a_mag, b_mag;
  logic signed [TRIG_W-1:0] sn, cs, sin_d, cos_d;

  always_comb begin
    a_mag = sf_q.swap ? tcf_q : tsf_q;
    b_mag = sf_q.swap ? tsf_q : tcf_q;
    sn    = signed'(TRIG_W'(a_mag));
    cs    = signed'(TRIG_W'(b_mag));
    case (sf_q.quad)
      2'd0:    begin sin_d = sn;  cos_d = cs;  end
      2'd1:    begin sin_d = cs;  cos_d = -sn; end
      2'd2:    begin sin_d = -sn; cos_d = -cs; end
      default: begin sin_d = -cs; cos_d = sn;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sf_q  <= side_c[HORNER_N];
      tsf_q <= fprod[TQ +: TW];
      tcf_q <= tc_c[HORNER_N];
      sin_o <= sin_d;
      cos_o <= cos_d;
    end
  end

endmodule

// File: src/kbse_front.sv
module kbse_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [kbse_pkg::ANGLE_W-1:0]   u_angle_i,
  input  logic [kbse_pkg::ANGLE_W-1:0]   v_angle_i,
  input  logic [kbse_pkg::ORDER_W-1:0]   u_order_i,
  input  logic [kbse_pkg::ORDER_W-1:0]   v_order_i,
  output logic                           item_valid_o,
  output kbse_pkg::kbse_item_t           item_o,
  input  logic                           take_i
);
  import kbse_pkg::*;

  localparam int unsigned MW = TRIG_W - 1;

  logic adv;
  logic vld_q [FRONT_LAT];
  logic [2*ORDER_W-1:0] ord_q [FRONT_LAT];
  logic [ORDER_W-1:0] uo_c, vo_c;

  assign adv        = !vld_q[FRONT_LAT-1] || take_i;
  assign in_ready_o = adv;

  assign uo_c = (u_order_i > ORDER_MAX) ? ORDER_MAX : u_order_i;
  assign vo_c = (v_order_i > ORDER_MAX) ? ORDER_MAX : v_order_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < FRONT_LAT; n++) vld_q[n] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int n = 1; n < FRONT_LAT; n++) vld_q[n] <= vld_q[n-1];
    end
  end

  // trig of u/2, u, v, 2v (angles in half-units, so shifts double them)
  logic signed [TRIG_W-1:0] hs, hc, fus, fuc, fvs, fvc, f2s, f2c;

  kbse_trig u_trig_hu (
    .clk_i, .en_i(adv), .angle_i(u_angle_i), .sin_o(hs), .cos_o(hc)
  );
  kbse_trig u_trig_fu (
    .clk_i, .en_i(adv), .angle_i({u_angle_i[ANGLE_W-2:0], 1'b0}), .sin_o(fus), .cos_o(fuc)
  );
  kbse_trig u_trig_fv (
    .clk_i, .en_i(adv), .angle_i({v_angle_i[ANGLE_W-2:0], 1'b0}), .sin_o(fvs), .cos_o(fvc)
  );
  kbse_trig u_trig_f2v (
    .clk_i, .en_i(adv), .angle_i({v_angle_i[ANGLE_W-3:0], 2'b0}), .sin_o(f2s), .cos_o(f2c)
  );

  // p1..p8 operand pairs
  logic signed [TRIG_W-1:0] opa [8];
  logic signed [TRIG_W-1:0] opb [8];
  always_comb begin
    opa[0] = hc; opb[0] = fvs;
    opa[1] = hs; opb[1] = f2s;
    opa[2] = hs; opb[2] = fvs;
    opa[3] = hc; opb[3] = f2s;
    opa[4] = hc; opb[4] = fvc;
    opa[5] = hs; opb[5] = f2c;
    opa[6] = hs; opb[6] = fvc;
    opa[7] = hc; opb[7] = f2c;
  end

  logic [MW-1:0]   ma_q [8];
  logic [MW-1:0]   mb_q [8];
  logic            ng1_q [8];
  logic [MW-1:0]   m_q  [8];
  logic            ng2_q [8];
  logic [2*MW-1:0] prod [8];
  logic signed [TRIG_W-1:0] fus_q [3];
  logic signed [TRIG_W-1:0] fuc_q [3];

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      prod[n] = (2*MW)'(ma_q[n]) * (2*MW)'(mb_q[n]) + ((2*MW)'(1) << (TQ - 1));
    end
  end

  logic signed [WB_W-1:0] pe [8];
  logic signed [WB_W-1:0] w_d [3];
  logic signed [WB_W-1:0] b_d [3];
  logic [WB_W-1:0] w_q [3];
  logic [WB_W-1:0] b_q [3];

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      pe[n] = ng2_q[n] ? -signed'(WB_W'(m_q[n])) : signed'(WB_W'(m_q[n]));
    end
    w_d[0] = pe[0] - pe[1];
    b_d[0] = pe[2] + pe[3];
    w_d[1] = pe[4] - (pe[5] <<< 1);
    b_d[1] = pe[6] + (pe[7] <<< 1);
    w_d[2] = (pe[1] <<< 2) - pe[0];
    b_d[2] = -pe[2] - (pe[3] <<< 2);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ord_q[0] <= {uo_c, vo_c};
      for (int n = 1; n < FRONT_LAT; n++) ord_q[n] <= ord_q[n-1];
      for (int n = 0; n < 8; n++) begin
        ma_q[n]  <= opa[n][TRIG_W-1] ? MW'(-opa[n]) : MW'(opa[n]);
        mb_q[n]  <= opb[n][TRIG_W-1] ? MW'(-opb[n]) : MW'(opb[n]);
        ng1_q[n] <= opa[n][TRIG_W-1] ^ opb[n][TRIG_W-1];
        m_q[n]   <= prod[n][TQ +: MW];
        ng2_q[n] <= ng1_q[n];
      end
      fus_q[0] <= fus;
      fuc_q[0] <= fuc;
      for (int n = 1; n < 3; n++) begin
        fus_q[n] <= fus_q[n-1];
        fuc_q[n] <= fuc_q[n-1];
      end
      for (int n = 0; n < 3; n++) begin
        w_q[n] <= w_d[n];
        b_q[n] <= b_d[n];
      end
    end
  end

  assign item_valid_o = vld_q[FRONT_LAT-1];
  always_comb begin
    item_o.uo   = ord_q[FRONT_LAT-1][2*ORDER_W-1:ORDER_W];
    item_o.vo   = ord_q[FRONT_LAT-1][ORDER_W-1:0];
    item_o.fu_s = fus_q[2];
    item_o.fu_c = fuc_q[2];
    for (int n = 0; n < 3; n++) begin
      item_o.w[n] = w_q[n];
      item_o.b[n] = b_q[n];
    end
  end

endmodule

// File: src/kbse_back.sv
module kbse_back #(
  parameter int unsigned FRAC_BITS = kbse_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  input  kbse_pkg::kbse_item_t           item_i,
  output logic                           take_o,
  input  logic [kbse_pkg::RADIUS_W-1:0]  radius_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [kbse_pkg::ORDER_W-1:0]   order_in_u_o,
  output logic [kbse_pkg::ORDER_W-1:0]   order_in_v_o,
  output logic signed [kbse_pkg::OUT_W-1:0] x_value_o,
  output logic signed [kbse_pkg::OUT_W-1:0] y_value_o,
  output logic signed [kbse_pkg::OUT_W-1:0] z_value_o,
  output logic                           last_o
);
  import kbse_pkg::*;

  localparam int unsigned RQ_W = RADIUS_W + TQ - FRAC_BITS;
  localparam int unsigned AW   = ((RQ_W > WB_W - 1) ? RQ_W : WB_W - 1) + 2;
  localparam int unsigned MW   = AW - 1;
  localparam int unsigned HW   = MW - TQ;
  localparam int unsigned TM_W = TRIG_W - 1;
  localparam int unsigned XW   = AW + 4;
  localparam int unsigned SH   = OUT_W - FRAC_BITS;
  localparam logic [XW-1:0] SAT_NEG = XW'(64'h8000_0000);
  localparam logic [XW-1:0] SAT_POS = XW'(64'h7FFF_FFFF);

  function automatic logic [OUT_W-1:0] to_field(input logic signed [XW-1:0] v);
    logic [XW-1:0] m;
    logic [XW-1:0] r;
    m = v[XW-1] ? XW'(-v) : XW'(v);
    r = (m + (XW'(1) << (SH - 1))) >> SH;
    if (v[XW-1]) begin
      if (r > SAT_NEG) r = SAT_NEG;
      to_field = OUT_W'(XW'(0) - r);
    end else begin
      if (r > SAT_POS) r = SAT_POS;
      to_field = OUT_W'(r);
    end
  endfunction

  logic back_adv;
  logic out_vld_q;
  assign back_adv = !out_vld_q || out_ready_i;

  // expander: one result request per cycle unless the output stalls
  kbse_item_t         itm_q;
  logic               hold_vld_q;
  logic [ORDER_W-1:0] i_q, j_q;
  logic               last_issue;

  assign last_issue = (i_q == itm_q.uo) && (j_q == itm_q.vo);
  assign take_o     = !hold_vld_q || (back_adv && last_issue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
    end else if (take_o) begin
      hold_vld_q <= item_valid_i;
      i_q        <= '0;
      j_q        <= '0;
    end else if (back_adv) begin
      if (j_q == itm_q.vo) begin
        j_q <= '0;
        i_q <= i_q + 1'b1;
      end else begin
        j_q <= j_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) itm_q <= item_i;
  end

  // ---------------- E1: select row, add radius ------------------------
  logic [AW-1:0]            rq_ext;
  logic signed [AW-1:0]     a_d;
  logic signed [WB_W-1:0]   wsel, bsel;

  assign rq_ext = AW'(radius_i) << (TQ - FRAC_BITS);
  always_comb begin
    wsel = signed'(itm_q.w[j_q]);
    bsel = signed'(itm_q.b[j_q]);
    a_d  = AW'(wsel) + ((j_q == '0) ? signed'(rq_ext) : signed'(AW'(0)));
  end

  logic                     e_vld_q [5];
  logic [ORDER_W-1:0]       ei_q [5];
  logic [ORDER_W-1:0]       ej_q [5];
  logic                     el_q [5];
  logic signed [WB_W-1:0]   eb_q [5];
  logic signed [WB_W-1:0]   ew_q [5];

  logic signed [AW-1:0]     e1_a_q;
  logic signed [TRIG_W-1:0] e1_fc_q, e1_fs_q;

  // E2: magnitudes
  logic signed [AW-1:0] src [3];
  logic [MW-1:0]        msrc_q [3];
  logic                 nsrc_q [3];
  logic [TM_W-1:0]      mtr_q [2];
  logic                 ntr_q [2];

  always_comb begin
    src[0] = e1_a_q;
    src[1] = AW'(eb_q[0]);
    src[2] = AW'(ew_q[0]);
  end

  // E3: split products, E4: sum, round, sign
  logic [HW+TM_W-1:0] hp_q [6];
  logic [TQ+TM_W-1:0] lp_q [6];
  logic               np_q [6];
  logic [AW-1:0]      msum [6];
  logic signed [AW-1:0] mq_q [6];

  always_comb begin
    for (int n = 0; n < 6; n++) begin
      msum[n] = AW'(hp_q[n]) + AW'(lp_q[n][TQ +: TM_W]);
    end
  end

  // E5: combine per u order
  logic signed [XW-1:0] pc, ps, bc, bs, wc, ws, bx, wx;
  logic signed [XW-1:0] x_d, y_d, z_d;
  logic signed [XW-1:0] x_q, y_q, z_q;

  always_comb begin
    pc = XW'(mq_q[0]);
    ps = XW'(mq_q[1]);
    bc = XW'(mq_q[2]);
    bs = XW'(mq_q[3]);
    wc = XW'(mq_q[4]);
    ws = XW'(mq_q[5]);
    bx = XW'(eb_q[3]);
    wx = XW'(ew_q[3]);
    case (ei_q[3])
      2'd0: begin
        x_d = pc <<< 2;
        y_d = ps <<< 2;
        z_d = bx <<< 2;
      end
      2'd1: begin
        x_d = -(bc <<< 1) - (ps <<< 2);
        y_d = -(bs <<< 1) + (pc <<< 2);
        z_d = wx <<< 1;
      end
      2'd2: begin
        x_d = -wc + (bs <<< 2) - (pc <<< 2);
        y_d = -ws - (bc <<< 2) - (ps <<< 2);
        z_d = -bx;
      end
      default: begin
        x_d = '0;
        y_d = '0;
        z_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 5; n++) e_vld_q[n] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (back_adv) begin
      e_vld_q[0] <= hold_vld_q;
      for (int n = 1; n < 5; n++) e_vld_q[n] <= e_vld_q[n-1];
      out_vld_q <= e_vld_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_adv) begin
      // E1
      e1_a_q  <= a_d;
      e1_fc_q <= signed'(itm_q.fu_c);
      e1_fs_q <= signed'(itm_q.fu_s);
      ei_q[0] <= i_q;
      ej_q[0] <= j_q;
      el_q[0] <= last_issue;
      eb_q[0] <= bsel;
      ew_q[0] <= wsel;
      for (int n = 1; n < 5; n++) begin
        ei_q[n] <= ei_q[n-1];
        ej_q[n] <= ej_q[n-1];
        el_q[n] <= el_q[n-1];
        eb_q[n] <= eb_q[n-1];
        ew_q[n] <= ew_q[n-1];
      end
      // E2
      for (int n = 0; n < 3; n++) begin
        msrc_q[n] <= src[n][AW-1] ? MW'(-src[n]) : MW'(src[n]);
        nsrc_q[n] <= src[n][AW-1];
      end
      mtr_q[0] <= e1_fc_q[TRIG_W-1] ? TM_W'(-e1_fc_q) : TM_W'(e1_fc_q);
      mtr_q[1] <= e1_fs_q[TRIG_W-1] ? TM_W'(-e1_fs_q) : TM_W'(e1_fs_q);
      ntr_q[0] <= e1_fc_q[TRIG_W-1];
      ntr_q[1] <= e1_fs_q[TRIG_W-1];
      // E3
      for (int s = 0; s < 3; s++) begin
        for (int t = 0; t < 2; t++) begin
          hp_q[s*2+t] <= (HW+TM_W)'(msrc_q[s][MW-1:TQ]) * (HW+TM_W)'(mtr_q[t]);
          lp_q[s*2+t] <= (TQ+TM_W)'(msrc_q[s][TQ-1:0]) * (TQ+TM_W)'(mtr_q[t])
                         + ((TQ+TM_W)'(1) << (TQ - 1));
          np_q[s*2+t] <= nsrc_q[s] ^ ntr_q[t];
        end
      end
      // E4
      for (int n = 0; n < 6; n++) begin
        mq_q[n] <= np_q[n] ? -signed'(msum[n]) : signed'(msum[n]);
      end
      // E5
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      // output register
      order_in_u_o <= ei_q[4];
      order_in_v_o <= ej_q[4];
      last_o       <= el_q[4];
      x_value_o    <= signed'(to_field(x_q));
      y_value_o    <= signed'(to_field(y_q));
      z_value_o    <= signed'(to_field(z_q));
    end
  end

  assign out_valid_o = out_vld_q;

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> (i_q <= itm_q.uo && j_q <= itm_q.vo))
    else $error("result index beyond requested orders");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_vld_q && back_adv && !last_issue) |=> hold_vld_q)
    else $error("request released before its last result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> ($stable(i_q) && $stable(j_q) && $stable(e_vld_q[4])))
    else $error("result pipe moved while output stalled");

  a_out_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (order_in_u_o <= ORDER_MAX && order_in_v_o <= ORDER_MAX))
    else $error("output order out of range");
`endif

endmodule

// File: src/klein_bottle_surface_eval_core.sv
// Figure-eight Klein bottle evaluator with partial derivatives up to order 2.
// Request channel: in_valid_i/in_ready_o with u_angle_i, v_angle_i (65536
//   units per turn) and u_order_i, v_order_i (3 is taken as 2).
// Result channel: out_valid_o/out_ready_i; one result per (i, j) pair,
//   i outer, carrying x/y/z in signed Q16.16 (FRAC_BITS fraction bits),
//   saturated; last_o marks the final result of a request.
// Config: radius_we_i writes radius_wdata_i (unsigned, FRAC_BITS fraction
//   bits); write only while no request is in flight.
// A request's results pass the front pipeline, the expander hold register,
//   stages E1 to E5 and the output register.
// Throughput: the result port moves one result per cycle while out_ready_i
//   is high; a request gives (u_order+1)*(v_order+1) results, 1 to 9; a new
//   request may be accepted every cycle while the trig pipeline has room.
// Reset clears all valid bits and sets radius to 1.0 (65536).
// A stalled receiver freezes the result pipeline; the trig pipeline keeps
//   filling until its last stage holds a request, then in_ready_o drops.
module klein_bottle_surface_eval_core #(
  parameter int unsigned FRAC_BITS = kbse_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              radius_we_i,
  input  logic [kbse_pkg::RADIUS_W-1:0]     radius_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kbse_pkg::ANGLE_W-1:0]      u_angle_i,
  input  logic [kbse_pkg::ANGLE_W-1:0]      v_angle_i,
  input  logic [kbse_pkg::ORDER_W-1:0]      u_order_i,
  input  logic [kbse_pkg::ORDER_W-1:0]      v_order_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [kbse_pkg::ORDER_W-1:0]      order_in_u_o,
  output logic [kbse_pkg::ORDER_W-1:0]      order_in_v_o,
  output logic signed [kbse_pkg::OUT_W-1:0] x_value_o,
  output logic signed [kbse_pkg::OUT_W-1:0] y_value_o,
  output logic signed [kbse_pkg::OUT_W-1:0] z_value_o,
  output logic                              last_o
);
  import kbse_pkg::*;

  // radius register
  logic [RADIUS_W-1:0] radius_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (radius_we_i) begin
      radius_q <= radius_wdata_i;
    end
  end

  // front: four trig pipelines, then the eight products and w/b terms
  kbse_item_t item;
  logic       item_valid;
  logic       take;

  kbse_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .u_angle_i,
    .v_angle_i,
    .u_order_i,
    .v_order_i,
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  // back: walk the (i, j) pairs, one result per cycle unless the output stalls
  kbse_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .radius_i     (radius_q),
    .out_valid_o,
    .out_ready_i,
    .order_in_u_o,
    .order_in_v_o,
    .x_value_o,
    .y_value_o,
    .z_value_o,
    .last_o
  );

endmodule
